/* hdl/radec_to_azel_top_defines.svh */
// Assertion macros for the coordinate converter.
`ifndef RADEC_TO_AZEL_TOP_DEFINES_SVH
`define RADEC_TO_AZEL_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define R2A_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define R2A_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define R2A_ASSERT(label, clk, rst_n, prop)
`define R2A_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hdl/r2a_pkg.sv */
`timescale 1ns / 1ps
package r2a_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned Frac = 60;
  localparam int unsigned AngleBits = 32;
  localparam logic [63:0] TwoPiQ60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] HalfTurn = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QuarterTurn = 64'h4000_0000_0000_0000;

  // floor(num * 2^bits / den), num < den < 2^63
  function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
                                           input int unsigned bits);
    logic [63:0] n, q;
    n = num;
    q = '0;
    for (int unsigned k = 0; k < bits; k++) begin
      n = n << 1;
      q = q << 1;
      if (n >= den) begin
        n = n - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in 2^-64 turn units
  function automatic logic [63:0] atan_tab(input int unsigned idx);
    logic [63:0] sum, term, r;
    int unsigned sh;
    sum = '0;
    r = '0;
    if (idx == 0) begin
      r = 64'h2000_0000_0000_0000;
    end else begin
      for (int unsigned k = 0; k < 31; k++) begin
        sh = idx * (2 * k + 1);
        if (sh <= Frac) begin
          term = ((64'd1 << Frac) >> sh) / 64'(2 * k + 1);
          if (k[0]) sum = sum - term;
          else sum = sum + term;
        end
      end
      r = frac_div(sum, TwoPiQ60, 64);
    end
    return r;
  endfunction

  localparam logic [63:0] GainK =
    frac_div(64'd607252935008881256, 64'd1000000000000000000, Frac);

  typedef enum logic [0:0] {
    MODE_ROTATE = 1'b0,
    MODE_VECTOR = 1'b1
  } cordic_mode_e;

  typedef struct packed {
    logic [31:0] right_ascension;
    logic signed [31:0] declination;
    logic [31:0] sidereal_time;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] azimuth;
    logic signed [31:0] elevation;
  } out_beat_t;

  function automatic logic [63:0] sar64(input logic [63:0] v, input logic [5:0] s);
    return 64'($signed(v) >>> s);
  endfunction
endpackage

/* hdl/r2a_cell.sv */
`timescale 1ns / 1ps
module r2a_cell import r2a_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic         clk_i,
  input  cordic_mode_e mode_i,
  input  logic [63:0]  x_i,
  input  logic [63:0]  y_i,
  input  logic [63:0]  z_i,
  output logic [63:0]  x_o,
  output logic [63:0]  y_o,
  output logic [63:0]  z_o
);
  localparam logic [5:0] Sh = 6'(Step);
  localparam logic [63:0] AtanStep = atan_tab(Step);
  logic [63:0] x_d, y_d, z_d, x_q, y_q, z_q, xs, ys;
  logic        dir;

  always_comb begin
    xs = sar64(x_i, Sh);
    ys = sar64(y_i, Sh);
    dir = (mode_i == MODE_ROTATE) ? z_i[63] : ~y_i[63];
    if (dir) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
    end
    if (dir) z_d = z_i + AtanStep;
    else z_d = z_i - AtanStep;
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

/* hdl/r2a_chain.sv */
`timescale 1ns / 1ps
module r2a_chain import r2a_pkg::*; #(
  parameter int unsigned Steps = 32
) (
  input  logic         clk_i,
  input  cordic_mode_e mode_i,
  input  logic [63:0]  x_i,
  input  logic [63:0]  y_i,
  input  logic [63:0]  z_i,
  output logic [63:0]  x_o,
  output logic [63:0]  y_o,
  output logic [63:0]  z_o
);
  logic [63:0] xv [Steps+1];
  logic [63:0] yv [Steps+1];
  logic [63:0] zv [Steps+1];
  assign xv[0] = x_i;
  assign yv[0] = y_i;
  assign zv[0] = z_i;
  for (genvar g = 0; g < Steps; g++) begin : g_cell
    r2a_cell #(.Step(g)) u_cell (
      .clk_i, .mode_i,
      .x_i(xv[g]), .y_i(yv[g]), .z_i(zv[g]),
      .x_o(xv[g+1]), .y_o(yv[g+1]), .z_o(zv[g+1])
    );
  end
  assign x_o = xv[Steps];
  assign y_o = yv[Steps];
  assign z_o = zv[Steps];
endmodule

/* hdl/r2a_mul.sv */
`timescale 1ns / 1ps
module r2a_mul import r2a_pkg::*; (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] am, bm;
  logic [63:0] ll_q, lh_q, hl_q, hh_q;
  logic        neg_q;
  logic [95:0] mid;
  logic [127:0] full;
  logic [63:0] r;

  assign am = a_i[63] ? 64'(-a_i) : a_i;
  assign bm = b_i[63] ? 64'(-b_i) : b_i;

  always_ff @(posedge clk_i) begin
    ll_q <= am[31:0] * bm[31:0];
    lh_q <= am[31:0] * bm[63:32];
    hl_q <= am[63:32] * bm[31:0];
    hh_q <= am[63:32] * bm[63:32];
    neg_q <= a_i[63] ^ b_i[63];
  end

  always_comb begin
    mid = 96'(lh_q) + 96'(hl_q);
    full = {hh_q, ll_q} + {mid, 32'd0};
    r = full[Frac +: 64];
  end

  always_ff @(posedge clk_i) begin
    p_o <= neg_q ? 64'(-r) : r;
  end
endmodule

/* hdl/radec_to_azel_top.sv */
`timescale 1ns / 1ps
// done_o marks the result of the beat taken with start_i; the valid pipe vld_q tracks it.
// Three cell chains in series, two multiplier levels and the magnitude multiply make up the path.
// Throughput: one beat per cycle; busy_o is tied low as every stage advances each cycle.
// Reset clears the valid pipe and site latitude; data registers are not reset.
// The receiver cannot stall: done_o marks each result for one cycle.
`include "radec_to_azel_top_defines.svh"
module radec_to_azel_top import r2a_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_beat_t  in_i,
  input  logic      cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic      done_o,
  output out_beat_t out_o
);
  localparam int unsigned Up = 64 - AngleBits;
  localparam int unsigned Lat = 3 * CORDIC_STEPS + 12;
  logic [63:0] lat_q;
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) lat_q <= {cfg_wdata_i[AngleBits-1:0], Up'(0)};
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end
  assign busy_o = 1'b0;

  // stage 0: reduce angles
  logic [63:0] ha, dc;
  logic [63:0] h0_q, d0_q, l0_q;
  logic        fh_q, fd_q, fl_q;
  assign ha = {in_i.sidereal_time[AngleBits-1:0], Up'(0)}
            - {in_i.right_ascension[AngleBits-1:0], Up'(0)};
  assign dc = {in_i.declination[AngleBits-1:0], Up'(0)};
  logic [63:0] hq, dq, lq;
  assign hq = ha + QuarterTurn;
  assign dq = dc + QuarterTurn;
  assign lq = lat_q + QuarterTurn;
  always_ff @(posedge clk_i) begin
    fh_q <= hq[63];
    fd_q <= dq[63];
    fl_q <= lq[63];
    h0_q <= hq[63] ? ha - HalfTurn : ha;
    d0_q <= dq[63] ? dc - HalfTurn : dc;
    l0_q <= lq[63] ? lat_q - HalfTurn : lat_q;
  end

  logic [63:0] hx, hy, dx, dy, lx, ly, unz1, unz2, unz3;
  r2a_chain #(.Steps(CORDIC_STEPS)) u_h (.clk_i, .mode_i(MODE_ROTATE),
    .x_i(GainK), .y_i('0), .z_i(h0_q), .x_o(hx), .y_o(hy), .z_o(unz1));
  r2a_chain #(.Steps(CORDIC_STEPS)) u_d (.clk_i, .mode_i(MODE_ROTATE),
    .x_i(GainK), .y_i('0), .z_i(d0_q), .x_o(dx), .y_o(dy), .z_o(unz2));
  r2a_chain #(.Steps(CORDIC_STEPS)) u_l (.clk_i, .mode_i(MODE_ROTATE),
    .x_i(GainK), .y_i('0), .z_i(l0_q), .x_o(lx), .y_o(ly), .z_o(unz3));

  logic [CORDIC_STEPS-1:0] fh_p, fd_p, fl_p;
  always_ff @(posedge clk_i) begin
    fh_p <= {fh_p[CORDIC_STEPS-2:0], fh_q};
    fd_p <= {fd_p[CORDIC_STEPS-2:0], fd_q};
    fl_p <= {fl_p[CORDIC_STEPS-2:0], fl_q};
  end
  logic [63:0] ch_q, sh_q, cd_q, sd_q, cl_q, sl_q;
  always_ff @(posedge clk_i) begin
    ch_q <= fh_p[CORDIC_STEPS-1] ? 64'(-hx) : hx;
    sh_q <= fh_p[CORDIC_STEPS-1] ? 64'(-hy) : hy;
    cd_q <= fd_p[CORDIC_STEPS-1] ? 64'(-dx) : dx;
    sd_q <= fd_p[CORDIC_STEPS-1] ? 64'(-dy) : dy;
    cl_q <= fl_p[CORDIC_STEPS-1] ? 64'(-lx) : lx;
    sl_q <= fl_p[CORDIC_STEPS-1] ? 64'(-ly) : ly;
  end

  // products, level 1
  logic [63:0] chcd, shcd, sdcl, sdsl;
  logic [63:0] cl1_q, cl2_q, sl1_q, sl2_q;
  r2a_mul u_m0 (.clk_i, .a_i(ch_q), .b_i(cd_q), .p_o(chcd));
  r2a_mul u_m1 (.clk_i, .a_i(sh_q), .b_i(cd_q), .p_o(shcd));
  r2a_mul u_m2 (.clk_i, .a_i(sd_q), .b_i(cl_q), .p_o(sdcl));
  r2a_mul u_m3 (.clk_i, .a_i(sd_q), .b_i(sl_q), .p_o(sdsl));
  always_ff @(posedge clk_i) begin
    cl1_q <= cl_q; cl2_q <= cl1_q;
    sl1_q <= sl_q; sl2_q <= sl1_q;
  end
  logic [63:0] chsl, chcl, yy1, yy2, a1, a2, b1, b2;
  r2a_mul u_m4 (.clk_i, .a_i(chcd), .b_i(sl2_q), .p_o(chsl));
  r2a_mul u_m5 (.clk_i, .a_i(chcd), .b_i(cl2_q), .p_o(chcl));
  always_ff @(posedge clk_i) begin
    yy1 <= 64'(-shcd); yy2 <= yy1;
    a1 <= sdcl; a2 <= a1;
    b1 <= sdsl; b2 <= b1;
  end
  logic [63:0] x_q, y_q, z_q;
  always_ff @(posedge clk_i) begin
    x_q <= a2 - chsl;
    y_q <= yy2;
    z_q <= chcl + b2;
  end

  // azimuth vectoring
  logic [63:0] vx_q, vy_q, vz_q, zpipe_q [CORDIC_STEPS];
  logic        az0_q, az0p [CORDIC_STEPS];
  always_ff @(posedge clk_i) begin
    az0_q <= (x_q == '0) && (y_q == '0);
    vx_q <= x_q[63] ? 64'(-x_q) : x_q;
    vy_q <= x_q[63] ? 64'(-y_q) : y_q;
    vz_q <= x_q[63] ? HalfTurn : '0;
    zpipe_q[0] <= z_q;
    az0p[0] <= az0_q;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      zpipe_q[i] <= zpipe_q[i-1];
      az0p[i] <= az0p[i-1];
    end
  end
  logic [63:0] ax, ay, az;
  r2a_chain #(.Steps(CORDIC_STEPS)) u_az (.clk_i, .mode_i(MODE_VECTOR),
    .x_i(vx_q), .y_i(vy_q), .z_i(vz_q), .x_o(ax), .y_o(ay), .z_o(az));

  logic [63:0] r_mag, azk1, azk2, azk3, zz1, zz2, zz3;
  r2a_mul u_mk (.clk_i, .a_i(ax), .b_i(GainK), .p_o(r_mag));
  always_ff @(posedge clk_i) begin
    azk1 <= az0p[CORDIC_STEPS-1] ? '0 : az;
    azk2 <= azk1;
    zz1 <= zpipe_q[CORDIC_STEPS-1]; zz2 <= zz1; zz3 <= zz2;
  end
  // elevation vectoring, R is non-negative
  logic [63:0] ex_q, ey_q, ez_q, azp_q [CORDIC_STEPS+1];
  always_ff @(posedge clk_i) begin
    ex_q <= r_mag;
    ey_q <= zz3;
    ez_q <= '0;
    azk3 <= azk2;
    azp_q[0] <= azk3;
    for (int i = 1; i <= CORDIC_STEPS; i++) azp_q[i] <= azp_q[i-1];
  end
  logic        e0_q, e0p [CORDIC_STEPS];
  always_ff @(posedge clk_i) begin
    e0_q <= (r_mag == '0) && (zz3 == '0);
    e0p[0] <= e0_q;
    for (int i = 1; i < CORDIC_STEPS; i++) e0p[i] <= e0p[i-1];
  end
  logic [63:0] elx, ely, elz;
  r2a_chain #(.Steps(CORDIC_STEPS)) u_el (.clk_i, .mode_i(MODE_VECTOR),
    .x_i(ex_q), .y_i(ey_q), .z_i(ez_q), .x_o(elx), .y_o(ely), .z_o(elz));

  logic [63:0] rnd_az, rnd_el;
  assign rnd_az = azp_q[CORDIC_STEPS-1] + (64'd1 << (Up - 1));
  assign rnd_el = (e0p[CORDIC_STEPS-1] ? '0 : elz) + (64'd1 << (Up - 1));
  always_ff @(posedge clk_i) begin
    out_o.azimuth <= 32'(rnd_az[63:Up]);
    out_o.elevation <= 32'(rnd_el[63:Up]);
  end
  assign done_o = vld_q[Lat-1];

  logic unused_ok;
  assign unused_ok = ^{unz1, unz2, unz3, ay, elx, ely, azp_q[CORDIC_STEPS]};

  `R2A_ASSERT(a_busy_low, clk_i, rst_ni, !busy_o)
  `R2A_ASSERT(a_done_follows, clk_i, rst_ni, done_o |-> vld_q[Lat-1])
  `R2A_ASSERT(a_no_ghost, clk_i, rst_ni, (vld_q == '0) |=> !done_o)
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import r2a_pkg::*;

  class azel_scoreboard;
    bit [63:0] arctan_turns[64];
    bit [63:0] cordic_gain;
    bit [31:0] latitude;
    out_beat_t pending_azel[$];
    int errors;

    function bit [63:0] div_frac(bit [63:0] n, bit [63:0] d, int bits);
      bit [63:0] q;
      q = '0;
      for (int k = 0; k < bits; k++) begin
        n = n << 1;
        q = q << 1;
        if (n >= d) begin
          n = n - d;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function new();
      bit [63:0] acc;
      bit [63:0] term;
      latitude = '0;
      errors = 0;
      arctan_turns[0] = 64'h1 << 61;
      for (int i = 1; i < 64; i++) begin
        acc = '0;
        for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
          term = ((64'h1 << 60) >> (i * (2 * k + 1))) / (2 * k + 1);
          if (k % 2) acc = acc - term;
          else acc = acc + term;
        end
        arctan_turns[i] = div_frac(acc, 64'h6487ED5110B4611A, 64);
      end
      cordic_gain = div_frac(64'd607252935008881256, 64'd1000000000000000000, 60);
    endfunction

    function bit [63:0] shr_arith(bit [63:0] v, int s);
      return $signed(v) >>> s;
    endfunction

    function bit [63:0] mul_q60(bit [63:0] a, bit [63:0] b);
      bit neg;
      bit [127:0] p;
      bit [63:0] r;
      neg = a[63] ^ b[63];
      if (a[63]) a = -a;
      if (b[63]) b = -b;
      p = {64'b0, a} * {64'b0, b};
      r = p[123:60];
      return neg ? -r : r;
    endfunction

    function void rotate_sincos(input bit [63:0] t, output bit [63:0] c,
                                output bit [63:0] s);
      bit flip;
      bit [63:0] x, y, z, nx;
      flip = 1'b0;
      x = cordic_gain;
      y = '0;
      if (((t + 64'h4000_0000_0000_0000) >> 63) != 0) begin
        t = t - 64'h8000_0000_0000_0000;
        flip = 1'b1;
      end
      z = t;
      for (int i = 0; i < 32; i++) begin
        if (z[63]) begin
          nx = x + shr_arith(y, i);
          y = y - shr_arith(x, i);
          z = z + arctan_turns[i];
        end else begin
          nx = x - shr_arith(y, i);
          y = y + shr_arith(x, i);
          z = z - arctan_turns[i];
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function bit [63:0] vector_angle(input bit [63:0] x, input bit [63:0] y,
                                     output bit [63:0] mag);
      bit [63:0] z, nx;
      z = '0;
      if (x == 0 && y == 0) begin
        mag = '0;
        return '0;
      end
      if (x[63]) begin
        x = -x;
        y = -y;
        z = 64'h8000_0000_0000_0000;
      end
      for (int i = 0; i < 32; i++) begin
        if (y[63]) begin
          nx = x - shr_arith(y, i);
          y = y + shr_arith(x, i);
          z = z - arctan_turns[i];
        end else begin
          nx = x + shr_arith(y, i);
          y = y - shr_arith(x, i);
          z = z + arctan_turns[i];
        end
        x = nx;
      end
      mag = mul_q60(x, cordic_gain);
      return z;
    endfunction

    function bit [31:0] round_turn(bit [63:0] a);
      bit [63:0] t;
      t = a + 64'h8000_0000;
      return t[63:32];
    endfunction

    function void note_input(in_beat_t b);
      bit [63:0] ha, ch, sh, cd, sd, cl, sl, chcd, vx, vy, vz, rho, spare, az, el;
      out_beat_t e;
      ha = {b.sidereal_time, 32'b0} - {b.right_ascension, 32'b0};
      rotate_sincos(ha, ch, sh);
      rotate_sincos({b.declination, 32'b0}, cd, sd);
      rotate_sincos({latitude, 32'b0}, cl, sl);
      chcd = mul_q60(ch, cd);
      vx = mul_q60(sd, cl) - mul_q60(chcd, sl);
      vy = -mul_q60(sh, cd);
      vz = mul_q60(chcd, cl) + mul_q60(sd, sl);
      az = vector_angle(vx, vy, rho);
      el = vector_angle(rho, vz, spare);
      e.azimuth = round_turn(az);
      e.elevation = round_turn(el);
      pending_azel.push_back(e);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t e;
      if (pending_azel.size() == 0) begin
        errors++;
        $display("%0t: unexpected result az=%h el=%h", $time, got.azimuth, got.elevation);
        return;
      end
      e = pending_azel.pop_front();
      if (got.azimuth !== e.azimuth) begin
        errors++;
        $display("%0t: azimuth expected %h actual %h", $time, e.azimuth, got.azimuth);
      end
      if (got.elevation !== e.elevation) begin
        errors++;
        $display("%0t: elevation expected %h actual %h", $time, e.elevation, got.elevation);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_beat_t in_i;
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic done_o;
  out_beat_t out_o;

  azel_scoreboard sb;
  int stall_cycles = 0;
  bit no_gaps;

  radec_to_azel_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .in_i(in_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o), .out_o(out_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.latitude = cfg_wdata_i;
      if (start_i && !busy_o) begin
        sb.note_input(in_i);
      end
      if (done_o) begin
        sb.check_result(out_o);
      end
      if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 3000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(10);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_azel.size() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  task automatic write_latitude(input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_beat_t mk(logic [31:0] ra, logic [31:0] dec, logic [31:0] lst);
    in_beat_t b;
    b.right_ascension = ra;
    b.declination = dec;
    b.sidereal_time = lst;
    return b;
  endfunction

  task automatic directed_set(input logic [31:0] lat);
    no_gaps = 1'b0;
    send_beat(mk(32'h0, 32'h0, 32'h0));
    send_beat(mk(32'hFFFF_FFFF, 32'h4000_0000, 32'h0));
    send_beat(mk(32'h0, 32'hC000_0000, 32'hFFFF_FFFF));
    send_beat(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(mk(32'h1234_5678, lat, 32'h1234_5678));
    send_beat(mk(32'h0, -lat, 32'h8000_0000));
    send_beat(mk(32'h4000_0000, 32'h8000_0000, 32'h0));
    send_beat(mk(32'h0, 32'h7FFF_FFFF, 32'hC000_0000));
    send_beat(mk(32'h8000_0000, 32'h0000_0001, 32'h4000_0000));
    send_beat(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555));
    send_beat(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA));
    send_beat(mk(32'h0, 32'h2000_0000, 32'h0000_0001));
    send_beat(mk(32'h0, 32'hE000_0000, 32'hFFFF_FFFF));
  endtask

  task automatic random_set(input int n);
    logic [31:0] dec;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) dec = $urandom;
      else dec = $urandom_range(32'h8000_0000) - 32'h4000_0000;
      send_beat(mk($urandom, dec, $urandom));
    end
  endtask

  initial begin
    logic [31:0] lats[7];
    sb = new();
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    lats[0] = 32'h0;
    lats[1] = 32'h4000_0000;
    lats[2] = 32'hC000_0000;
    lats[3] = $urandom_range(32'h8000_0000) - 32'h4000_0000;
    lats[4] = 32'h8000_0000;
    lats[5] = $urandom;
    lats[6] = 32'h0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_set(32'h0);
    drain();
    foreach (lats[p]) begin
      write_latitude(lats[p]);
      directed_set(lats[p]);
      random_set(160);
      drain();
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
